@@ hw/rtl/assert_macros.svh @@
// assert_macros.svh: assertion macros shared by the RTL.
// Assertions are clocked on clk and disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// expr must hold at every edge
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// ante implies cons in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// ante implies cons in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/pidc_pkg.sv @@
// pidc_pkg: widths, constants and control types of the PID position controller.
// No dependencies.
`default_nettype none

package pidc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SUM_WIDTH = 48;

  localparam int DATA_W    = 32;
  localparam int WIN_W     = 31;
  localparam int DT_W      = 16;
  localparam int CFG_IDX_W = 3;

  localparam int DIV_W     = DATA_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int MUL_OP_W  = DATA_W + 1;
  localparam int PROD_W    = 2 * MUL_OP_W;
  localparam int ET_W      = DATA_W + DT_W + 1;
  localparam int ADD_W     = ((SUM_WIDTH > ET_W) ? SUM_WIDTH : ET_W) + 1;
  localparam int ACC_W     = SUM_WIDTH + DATA_W + 2;
  localparam int SH_W      = ACC_W - FRAC_BITS;
  localparam int HI_W      = SUM_WIDTH - DATA_W;

  localparam logic [DATA_W-1:0]    S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0]    S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_KP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INT_WIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DONE_WIN = 3'd5;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef enum logic [2:0] {
    MUL_ERR_DT,
    MUL_KP_ERR,
    MUL_KI_LO,
    MUL_KI_HI,
    MUL_KD_DRV
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_HI
  } acc_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_ET,
    ST_SUM,
    ST_ACC_KP,
    ST_ACC_KILO,
    ST_ACC_KIHI,
    ST_WAIT_DIV,
    ST_MUL_KD,
    ST_ACC_KD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     sum_update;
    logic     deriv_load;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic div_busy;
  } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/pidc_div.sv @@
// pidc_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on pidc_pkg.
`default_nettype none

module pidc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pidc_pkg::DIV_W-1:0]  num,
  input  logic [pidc_pkg::DT_W-1:0]   den,
  output logic                        busy,
  output logic [pidc_pkg::DIV_W-1:0]  quot
);
  import pidc_pkg::*;

  logic [DT_W-1:0]      rem;
  logic [DIV_W-1:0]     qn;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DT_W:0]        trial;
  logic                 ge;

  assign trial = {rem, qn[DIV_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign quot  = qn;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // dividend bits shift out the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      qn  <= num;
    end else if (busy) begin
      rem <= ge ? DT_W'(trial - {1'b0, den}) : trial[DT_W-1:0];
      qn  <= {qn[DIV_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pidc_dp.sv @@
// pidc_dp: datapath of the PID controller: config registers, error, integral,
// shared multiplier, accumulator and output registers. Depends on pidc_pkg, pidc_div.
`default_nettype none

module pidc_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pidc_pkg::DATA_W-1:0]     cfg_data,
  input  logic                            op,
  input  logic signed [pidc_pkg::DATA_W-1:0] measurement,
  input  logic [pidc_pkg::DT_W-1:0]       elapsed_ms,
  input  pidc_pkg::cmd_t                  cmd,
  output pidc_pkg::sts_t                  sts,
  output logic signed [pidc_pkg::DATA_W-1:0] drive,
  output logic                            done_res,
  output logic signed [pidc_pkg::DATA_W-1:0] error_out
);
  import pidc_pkg::*;

  logic signed [DATA_W-1:0]    kp, ki, kd, target;
  logic [WIN_W-1:0]            iwin, dwin;

  logic                        op_r;
  logic [DT_W-1:0]             dt;
  logic signed [DATA_W-1:0]    err, prior, deriv;
  logic signed [SUM_WIDTH-1:0] esum;
  logic signed [PROD_W-1:0]    prod;
  logic signed [ACC_W-1:0]     acc;
  logic                        div_neg;

  logic signed [DATA_W:0]      diff_in;
  logic [DATA_W-1:0]           err_sat;
  logic [DATA_W-1:0]           aerr;
  logic signed [DATA_W:0]      pdiff;
  logic [DATA_W:0]             pmag;
  logic [DIV_W-1:0]            num;
  logic [DIV_W-1:0]            quot;
  logic                        div_busy;
  logic                        q_big_pos, q_big_neg;
  logic [DATA_W-1:0]           deriv_next;
  logic signed [MUL_OP_W-1:0]  mul_a, mul_b;
  logic signed [ET_W-1:0]      et;
  logic signed [ADD_W-1:0]     sw;
  logic                        sw_fits;
  logic [SUM_WIDTH-1:0]        sum_sat;
  logic signed [ACC_W-1:0]     prod_ext;
  logic [SH_W-1:0]             sh;
  logic                        sh_fits;
  logic [DATA_W-1:0]           drive_sat;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kp     <= '0;
      ki     <= '0;
      kd     <= '0;
      target <= '0;
      iwin   <= '0;
      dwin   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KP:       kp     <= cfg_data;
        REG_KI:       ki     <= cfg_data;
        REG_KD:       kd     <= cfg_data;
        REG_TARGET:   target <= cfg_data;
        REG_INT_WIN:  iwin   <= cfg_data[WIN_W-1:0];
        REG_DONE_WIN: dwin   <= cfg_data[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated error of the incoming word
  assign diff_in = {target[DATA_W-1], target} - {measurement[DATA_W-1], measurement};
  assign err_sat = (diff_in[DATA_W] != diff_in[DATA_W-1])
                   ? (diff_in[DATA_W] ? S32_MIN : S32_MAX) : diff_in[DATA_W-1:0];
  assign aerr    = err[DATA_W-1] ? $unsigned(-err) : $unsigned(err);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= op;
      dt   <= elapsed_ms;
      err  <= err_sat;
    end
  end

  // derivative: |err - prior| << FRAC_BITS divided by dt, sign applied after
  assign pdiff = {err[DATA_W-1], err} - {prior[DATA_W-1], prior};
  assign pmag  = pdiff[DATA_W] ? $unsigned(-pdiff) : $unsigned(pdiff);
  assign num   = {pmag[DATA_W-1:0], {FRAC_BITS{1'b0}}};

  pidc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (dt),
    .busy  (div_busy),
    .quot  (quot)
  );

  assign q_big_pos = |quot[DIV_W-1:DATA_W-1];
  assign q_big_neg = (|quot[DIV_W-1:DATA_W]) ||
                     (quot[DATA_W-1] && (|quot[DATA_W-2:0]));

  always_comb begin
    if (dt == '0) begin
      deriv_next = '0;
    end else if (div_neg) begin
      deriv_next = q_big_neg ? S32_MIN : DATA_W'(-quot[DATA_W-1:0]);
    end else begin
      deriv_next = q_big_pos ? S32_MAX : quot[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_neg <= pdiff[DATA_W];
    end
    if (cmd.deriv_load) begin
      deriv <= deriv_next;
    end
  end

  // shared 33x33 signed multiplier, registered product
  always_comb begin
    case (cmd.mul_sel)
      MUL_ERR_DT: begin
        mul_a = {err[DATA_W-1], err};
        mul_b = {{(MUL_OP_W-DT_W){1'b0}}, dt};
      end
      MUL_KP_ERR: begin
        mul_a = {kp[DATA_W-1], kp};
        mul_b = {err[DATA_W-1], err};
      end
      MUL_KI_LO: begin
        mul_a = {ki[DATA_W-1], ki};
        mul_b = {1'b0, esum[DATA_W-1:0]};
      end
      MUL_KI_HI: begin
        mul_a = {ki[DATA_W-1], ki};
        mul_b = {{(MUL_OP_W-HI_W){esum[SUM_WIDTH-1]}}, esum[SUM_WIDTH-1:DATA_W]};
      end
      MUL_KD_DRV: begin
        mul_a = {kd[DATA_W-1], kd};
        mul_b = {deriv[DATA_W-1], deriv};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // integral: saturating add of err * dt while |err| < iwin; zeroed when err is 0
  assign et      = prod[ET_W-1:0];
  assign sw      = ADD_W'(esum) + ADD_W'(et);
  assign sw_fits = (&sw[ADD_W-1:SUM_WIDTH-1]) || !(|sw[ADD_W-1:SUM_WIDTH-1]);
  assign sum_sat = sw_fits ? sw[SUM_WIDTH-1:0] : (sw[ADD_W-1] ? SUM_MIN : SUM_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      esum  <= '0;
      prior <= '0;
    end else begin
      if (cmd.sum_update) begin
        if (err == '0) begin
          esum <= '0;
        end else if (aerr < {1'b0, iwin}) begin
          esum <= sum_sat;
        end
      end else if (cmd.out_load && op_r == OP_START) begin
        esum <= '0;
      end
      if (cmd.out_load) begin
        prior <= err;
      end
    end
  end

  // exact sum of the three gain terms
  assign prod_ext = ACC_W'(prod);

  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      ACC_LOAD:   acc <= prod_ext;
      ACC_ADD:    acc <= acc + prod_ext;
      ACC_ADD_HI: acc <= acc + {prod_ext[ACC_W-DATA_W-1:0], {DATA_W{1'b0}}};
      default: ;
    endcase
  end

  assign sh        = acc[ACC_W-1:FRAC_BITS];
  assign sh_fits   = (&sh[SH_W-1:DATA_W-1]) || !(|sh[SH_W-1:DATA_W-1]);
  assign drive_sat = sh_fits ? sh[DATA_W-1:0] : (sh[SH_W-1] ? S32_MIN : S32_MAX);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      drive     <= (op_r == OP_UPDATE) ? drive_sat : '0;
      done_res  <= aerr < {1'b0, dwin};
      error_out <= err;
    end
  end

  assign sts.op       = op_r;
  assign sts.div_busy = div_busy;

endmodule

`default_nettype wire

@@ hw/rtl/pidc_ctrl.sv @@
// pidc_ctrl: sequencer of the PID controller; drives datapath commands and
// the handshakes. Depends on pidc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pidc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            cfg_ready,
  input  pidc_pkg::sts_t  sts,
  output pidc_pkg::cmd_t  cmd
);
  import pidc_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.mul_sel    = MUL_ERR_DT;
    cmd.acc_op     = ACC_HOLD;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL_ET;
        end
      end
      ST_MUL_ET: begin
        if (sts.op == OP_START) begin
          state_next = ST_OUT;
        end else begin
          cmd.div_start = 1'b1;
          cmd.mul_sel   = MUL_ERR_DT;
          state_next    = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum_update = 1'b1;
        cmd.mul_sel    = MUL_KP_ERR;
        state_next     = ST_ACC_KP;
      end
      ST_ACC_KP: begin
        cmd.acc_op  = ACC_LOAD;
        cmd.mul_sel = MUL_KI_LO;
        state_next  = ST_ACC_KILO;
      end
      ST_ACC_KILO: begin
        cmd.acc_op  = ACC_ADD;
        cmd.mul_sel = MUL_KI_HI;
        state_next  = ST_ACC_KIHI;
      end
      ST_ACC_KIHI: begin
        cmd.acc_op = ACC_ADD_HI;
        state_next = ST_WAIT_DIV;
      end
      ST_WAIT_DIV: begin
        if (!sts.div_busy) begin
          cmd.deriv_load = 1'b1;
          state_next     = ST_MUL_KD;
        end
      end
      ST_MUL_KD: begin
        cmd.mul_sel = MUL_KD_DRV;
        state_next  = ST_ACC_KD;
      end
      ST_ACC_KD: begin
        cmd.acc_op = ACC_ADD;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        // hold the result until the output register frees up
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `ASSERT_IMPLIES(a_out_load_free, cmd.out_load, !out_valid || !out_stall, "output overwritten")
  `ASSERT_IMPLIES(a_deriv_after_div, cmd.deriv_load, !sts.div_busy, "derivative taken early")
  `ASSERT_IMPLIES(a_div_idle_at_out, state == ST_OUT, !sts.div_busy, "divider still running")
  `ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state != ST_IDLE, "word not taken")

endmodule

`default_nettype wire

@@ hw/rtl/pid_position_controller.sv @@
// pid_position_controller: position PID loop in encoder ticks.
// Input channel (in_valid/in_stall) carries one word: op (0 start, 1 update),
// measurement and elapsed_ms. Output channel (out_valid/out_stall) returns one
// word per input: drive, done_res and error_out.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes kp, ki, kd,
// target, integral_window and done_window at indexes 0..5; write only when idle.
// An update word steps through ST_MUL_ET, ST_SUM, ST_ACC_KP, ST_ACC_KILO,
// ST_ACC_KIHI, ST_WAIT_DIV, ST_MUL_KD, ST_ACC_KD and ST_OUT; the derivative
// divider, one quotient bit per cycle, runs from ST_MUL_ET and the shared
// multiplier's four products run alongside it. A start word goes from ST_MUL_ET
// straight to ST_OUT. One word is in flight at a time; the next word is
// accepted as soon as a result sits in the output register.
// If the receiver stalls, the result holds in the output register and a
// finished item waits until it is taken, keeping in_stall high meanwhile.
// Reset (rst, synchronous) clears the gains, windows, target, prior error and
// integral, and drops out_valid.
`default_nettype none

module pid_position_controller (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   op,
  input  logic signed [pidc_pkg::DATA_W-1:0]     measurement,
  input  logic [pidc_pkg::DT_W-1:0]              elapsed_ms,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [pidc_pkg::DATA_W-1:0]     drive,
  output logic                                   done_res,
  output logic signed [pidc_pkg::DATA_W-1:0]     error_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pidc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pidc_pkg::DATA_W-1:0]            cfg_data
);
  import pidc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic cfg_we;

  assign cfg_we = cfg_valid && cfg_ready;

  pidc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pidc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .op          (op),
    .measurement (measurement),
    .elapsed_ms  (elapsed_ms),
    .cmd         (cmd),
    .sts         (sts),
    .drive       (drive),
    .done_res    (done_res),
    .error_out   (error_out)
  );

endmodule

`default_nettype wire
